@@ rtl/core/jjy_fenc_pkg.sv @@
// Shared types and constants for the JJY timecode frame encoder.
// Depends on nothing; imported by every module of the block.
package jjy_fenc_pkg;

  localparam int FRAME_LEN = 60;
  localparam int SEC_W     = 6;

  typedef logic [1:0] sym_t;
  localparam sym_t SYM_ZERO = 2'd0;
  localparam sym_t SYM_ONE  = 2'd1;
  localparam sym_t SYM_MARK = 2'd2;

  typedef sym_t [FRAME_LEN-1:0] frame_t;

  typedef struct packed {
    logic [5:0] minute_value;
    logic [4:0] hour_value;
    logic [8:0] day_number;
    logic [6:0] year_value;
    logic [2:0] weekday_value;
    logic       spare_one;
    logic       spare_two;
    logic       leap_pending;
    logic       leap_insert;
  } jjy_req_t;

  typedef struct packed {
    logic [5:0] second_index;
    logic [1:0] pulse_symbol;
    logic       frame_end;
  } jjy_sym_t;

  // Handshake between the encoder stages and the cell row
  typedef struct packed {
    logic valid;
    logic take;
  } frm_hs_t;

  localparam int MARK_POS [7]  = '{0, 9, 19, 29, 39, 49, 59};
  localparam int MIN_POS  [7]  = '{1, 2, 3, 5, 6, 7, 8};
  localparam int MIN_WT   [7]  = '{40, 20, 10, 8, 4, 2, 1};
  localparam int HR_POS   [6]  = '{12, 13, 15, 16, 17, 18};
  localparam int HR_WT    [6]  = '{20, 10, 8, 4, 2, 1};
  localparam int DAY_POS  [10] = '{22, 23, 25, 26, 27, 28, 30, 31, 32, 33};
  localparam int DAY_WT   [10] = '{200, 100, 80, 40, 20, 10, 8, 4, 2, 1};
  localparam int YR_POS   [8]  = '{41, 42, 43, 44, 45, 46, 47, 48};
  localparam int YR_WT    [8]  = '{80, 40, 20, 10, 8, 4, 2, 1};
  localparam int WD_POS   [3]  = '{50, 51, 52};
  localparam int WD_WT    [3]  = '{4, 2, 1};
  localparam int CALL_SIGN[8]  = '{0, 0, 0, 1, 0, 1, 1, 0};

  localparam int DAY_SPLIT = 5;  // day weights handled in the first stage

  localparam int POS_HR_PAR  = 36;
  localparam int POS_MIN_PAR = 37;
  localparam int POS_SU1     = 38;
  localparam int POS_SU2     = 40;
  localparam int POS_LS1     = 53;
  localparam int POS_LS2     = 54;
  localparam int POS_CALL    = 41;
  localparam int POS_FB_LO   = 50;
  localparam int POS_FB_HI   = 58;

  localparam logic [5:0] MIN_FMT_B0 = 6'd15;
  localparam logic [5:0] MIN_FMT_B1 = 6'd45;
  localparam logic [2:0] WD_MOD     = 3'd7;

endpackage

@@ rtl/core/jjy_fenc_cell.sv @@
// One cell of the symbol row: holds one 2-bit symbol, loads or shifts.
// Depends on jjy_fenc_pkg.
module jjy_fenc_cell
  import jjy_fenc_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  sym_t load_sym,
  input  sym_t next_sym,
  output sym_t sym
);

  sym_t sym_r;

  always_ff @(posedge clk) begin
    if (load) begin
      sym_r <= load_sym;
    end else if (shift) begin
      sym_r <= next_sym;
    end
  end

  assign sym = sym_r;

endmodule

@@ rtl/core/jjy_fenc_build.sv @@
// Two-stage frame builder: greedy weighted encoding, parity and format-B overlay.
// Depends on jjy_fenc_pkg.
module jjy_fenc_build
  import jjy_fenc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  jjy_req_t req,
  output frm_hs_t  frm_hs_o,
  input  logic     frm_take,
  output frame_t   frm
);

  // stage 1 registers
  logic       s1_vld_r, s1_vld_nxt;
  logic [6:0] min_bits_r, min_bits_nxt;
  logic [5:0] hr_bits_r,  hr_bits_nxt;
  logic [7:0] yr_bits_r,  yr_bits_nxt;
  logic [2:0] wd_bits_r,  wd_bits_nxt;
  logic [DAY_SPLIT-1:0] dayh_bits_r, dayh_bits_nxt;
  logic [8:0] day_rem_r,  day_rem_nxt;
  logic [3:0] flags_r;
  logic       fmt_b_r, fmt_b_nxt;

  // stage 2 registers
  logic   s2_vld_r, s2_vld_nxt;
  frame_t frm_r, frm_nxt;

  logic s2_adv, s1_adv;

  assign s2_adv    = !s2_vld_r || frm_take;
  assign s1_adv    = s1_vld_r && s2_adv;
  assign req_ready = !s1_vld_r || s2_adv;

  // stage 1: greedy subtraction for all fields but the low day weights
  always_comb begin
    logic [5:0] mrem;
    logic [4:0] hrem;
    logic [6:0] yrem;
    logic [2:0] wrem;
    logic [8:0] drem;
    mrem = req.minute_value;
    hrem = req.hour_value;
    yrem = req.year_value;
    wrem = (req.weekday_value == WD_MOD) ? 3'd0 : req.weekday_value;
    drem = req.day_number;
    for (int i = 0; i < 7; i++) begin
      min_bits_nxt[i] = (mrem >= 6'(MIN_WT[i]));
      if (min_bits_nxt[i]) mrem = mrem - 6'(MIN_WT[i]);
    end
    for (int i = 0; i < 6; i++) begin
      hr_bits_nxt[i] = (hrem >= 5'(HR_WT[i]));
      if (hr_bits_nxt[i]) hrem = hrem - 5'(HR_WT[i]);
    end
    for (int i = 0; i < 8; i++) begin
      yr_bits_nxt[i] = ({1'b0, yrem} >= 8'(YR_WT[i]));
      if (yr_bits_nxt[i]) yrem = yrem - 7'(YR_WT[i]);
    end
    for (int i = 0; i < 3; i++) begin
      wd_bits_nxt[i] = (wrem >= 3'(WD_WT[i]));
      if (wd_bits_nxt[i]) wrem = wrem - 3'(WD_WT[i]);
    end
    for (int i = 0; i < DAY_SPLIT; i++) begin
      dayh_bits_nxt[i] = (drem >= 9'(DAY_WT[i]));
      if (dayh_bits_nxt[i]) drem = drem - 9'(DAY_WT[i]);
    end
    day_rem_nxt = drem;
    fmt_b_nxt   = (req.minute_value == MIN_FMT_B0) || (req.minute_value == MIN_FMT_B1);
  end

  assign s1_vld_nxt = req_ready ? req_valid : s1_vld_r;
  assign s2_vld_nxt = s2_adv ? s1_vld_r : s2_vld_r;

  // stage 2: finish day, place every field, then overlay format B
  always_comb begin
    logic [8:0] drem;
    logic [9:0] day_bits;
    drem = day_rem_r;
    day_bits = '0;
    for (int i = 0; i < DAY_SPLIT; i++) day_bits[i] = dayh_bits_r[i];
    for (int i = DAY_SPLIT; i < 10; i++) begin
      day_bits[i] = (drem >= 9'(DAY_WT[i]));
      if (day_bits[i]) drem = drem - 9'(DAY_WT[i]);
    end

    frm_nxt = '{default: SYM_ZERO};
    for (int i = 0; i < 7; i++) frm_nxt[MARK_POS[i]] = SYM_MARK;
    for (int i = 0; i < 7; i++) frm_nxt[MIN_POS[i]] = {1'b0, min_bits_r[i]};
    for (int i = 0; i < 6; i++) frm_nxt[HR_POS[i]]  = {1'b0, hr_bits_r[i]};
    for (int i = 0; i < 10; i++) frm_nxt[DAY_POS[i]] = {1'b0, day_bits[i]};
    for (int i = 0; i < 8; i++) frm_nxt[YR_POS[i]]  = {1'b0, yr_bits_r[i]};
    for (int i = 0; i < 3; i++) frm_nxt[WD_POS[i]]  = {1'b0, wd_bits_r[i]};
    frm_nxt[POS_HR_PAR]  = {1'b0, ^hr_bits_r};
    frm_nxt[POS_MIN_PAR] = {1'b0, ^min_bits_r};
    frm_nxt[POS_SU1]     = {1'b0, flags_r[3]};
    frm_nxt[POS_SU2]     = {1'b0, flags_r[2]};
    frm_nxt[POS_LS1]     = {1'b0, flags_r[1]};
    frm_nxt[POS_LS2]     = {1'b0, flags_r[0]};
    if (fmt_b_r) begin
      frm_nxt[POS_SU2] = SYM_ZERO;
      for (int i = 0; i < 8; i++) frm_nxt[POS_CALL + i] = 2'(CALL_SIGN[i]);
      frm_nxt[MARK_POS[5]] = SYM_MARK;
      for (int i = POS_FB_LO; i <= POS_FB_HI; i++) frm_nxt[i] = SYM_ZERO;
      frm_nxt[MARK_POS[6]] = SYM_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      min_bits_r  <= min_bits_nxt;
      hr_bits_r   <= hr_bits_nxt;
      yr_bits_r   <= yr_bits_nxt;
      wd_bits_r   <= wd_bits_nxt;
      dayh_bits_r <= dayh_bits_nxt;
      day_rem_r   <= day_rem_nxt;
      flags_r     <= {req.spare_one, req.spare_two, req.leap_pending, req.leap_insert};
      fmt_b_r     <= fmt_b_nxt;
    end
    if (s1_adv) begin
      frm_r <= frm_nxt;
    end
  end

  assign frm_hs_o.valid = s2_vld_r;
  assign frm_hs_o.take  = frm_take;
  assign frm            = frm_r;

endmodule

@@ rtl/core/jjy_timecode_frame_encoder_unit.sv @@
// Top level of the JJY timecode frame encoder: builder stages and the symbol cell row.
// Depends on jjy_fenc_pkg, jjy_fenc_build and jjy_fenc_cell.
//
// Usage:
//   in_valid/in_ready/in_data carry one time request (minute, hour, day of
//   year, year, weekday and four flags). Each request yields sixty results on
//   out_valid/out_ready/out_data, seconds 0 to 59 in order, frame_end set on
//   second 59.
//   Path: a request is loaded into stage one at the accepting edge, then
//   into stage two, then by a parallel load into the cell row, after which
//   the first symbol is valid.
//   Throughput: one symbol per cycle while out_ready is high, set by the
//   sixty-cell row, which shifts one symbol out per cycle. The next frame
//   loads into the row in the same cycle the last symbol is taken, so
//   frames follow with no gap, and up to two further requests wait in the
//   encoder stages meanwhile.
//   Reset (rst_n low, synchronous) empties both stages and the row; nothing is
//   emitted until a request arrives.
//   A receiver stall (out_ready low) holds the head symbol and the position;
//   the encoder stages fill and then in_ready drops.
module jjy_timecode_frame_encoder_unit
  import jjy_fenc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jjy_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jjy_sym_t out_data
);

  frm_hs_t frm_hs;
  frame_t  frm;
  sym_t    cell_sym [FRAME_LEN];

  logic             busy_r, busy_nxt;
  logic [SEC_W-1:0] pos_r, pos_nxt;
  logic             last_pos;
  logic             out_acc;
  logic             load;

  jjy_fenc_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .frm_hs_o  (frm_hs),
    .frm_take  (load),
    .frm       (frm)
  );

  assign last_pos = (pos_r == SEC_W'(FRAME_LEN - 1));
  assign out_acc  = out_valid && out_ready;
  // Load a fresh frame when the row is empty or its last symbol leaves now
  assign load     = frm_hs.valid && (!busy_r || (out_acc && last_pos));

  // Row of cells; cell 0 is the head, each cell takes its right neighbor
  for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cell
    jjy_fenc_cell u_cell (
      .clk      (clk),
      .load     (load),
      .shift    (out_acc),
      .load_sym (frm[g]),
      .next_sym ((g == FRAME_LEN - 1) ? SYM_ZERO : cell_sym[(g + 1) % FRAME_LEN]),
      .sym      (cell_sym[g])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = '0;
    end else if (out_acc) begin
      // advance; drop to idle after the last second
      if (last_pos) begin
        busy_nxt = 1'b0;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign out_valid             = busy_r;
  assign out_data.second_index = pos_r;
  assign out_data.pulse_symbol = cell_sym[0];
  assign out_data.frame_end    = last_pos;

endmodule
